FILE: rtl/core/dara_pkg.sv
// Shared constants and types of the dynamic array range aggregate block.
`default_nettype none

package dara_pkg;

   localparam int VAL_W = 32;   // stored value and result width
   localparam int POS_W = 10;   // position field width
   localparam int MOD_W = 31;   // modulus register width
   localparam int OP_W  = 3;    // operation code width
   localparam int CSR_IDX_W = 1;

   typedef logic [OP_W-1:0] op_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam op_type OP_INSERT = 3'd0;
   localparam op_type OP_ERASE  = 3'd1;
   localparam op_type OP_CHANGE = 3'd2;
   localparam op_type OP_READ   = 3'd3;
   localparam op_type OP_RANGE  = 3'd4;
   localparam op_type OP_COUNT  = 3'd5;

   localparam csr_idx_type CSR_COMBINE = 1'd0;
   localparam csr_idx_type CSR_MODULUS = 1'd1;

   localparam logic [MOD_W-1:0] MODULUS_RST = 31'd1000000007;

endpackage

`default_nettype wire

FILE: rtl/core/dara_store.sv
// Element memory: one write port and one read port with registered read data.
`default_nettype none

module dara_store #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [dara_pkg::VAL_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic [dara_pkg::VAL_W-1:0]      rd_data
);

   logic [dara_pkg::VAL_W-1:0] mem_ff [DEPTH];
   logic [dara_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dara_modred.sv
// Bit-serial floored modulo reduction of a signed range sum.
`default_nettype none

module dara_modred #(
   parameter int SUM_W = 42
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [SUM_W-1:0]           sum,
   input  wire logic [dara_pkg::MOD_W-1:0] modulus,
   output logic                            done,
   output logic [dara_pkg::MOD_W-1:0]      result
);

   localparam int CNW = $clog2(SUM_W + 1);

   logic                       busy_ff, busy_in;
   logic [CNW-1:0]             cnt_ff, cnt_in;
   logic [SUM_W-1:0]           mag_ff, mag_in;
   logic [dara_pkg::MOD_W-1:0] rem_ff, rem_in;
   logic [dara_pkg::MOD_W-1:0] mod_ff, mod_in;
   logic                       neg_ff, neg_in;
   logic                       done_ff, done_in;
   logic [dara_pkg::MOD_W-1:0] result_ff, result_in;

   logic [dara_pkg::MOD_W:0]   trial;
   logic [dara_pkg::MOD_W:0]   diff;
   logic                       fits;

   // Restoring division of the magnitude, one quotient bit per cycle; only the
   // remainder is kept.
   assign trial = {rem_ff, mag_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, mod_ff};
   assign fits  = trial >= {1'b0, mod_ff};

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      mod_in    = mod_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(SUM_W);
         neg_in  = sum[SUM_W-1];
         mag_in  = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
         rem_in  = '0;
         mod_in  = modulus;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? diff[dara_pkg::MOD_W-1:0] : trial[dara_pkg::MOD_W-1:0];
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff - CNW'(1);
         end else begin
            // A negative sum with a nonzero remainder folds back into 0..mod-1.
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = (neg_ff && (rem_ff != '0)) ? (mod_ff - rem_ff) : rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mag_ff    <= mag_in;
      rem_ff    <= rem_in;
      mod_ff    <= mod_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("modulo unit started while busy");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (result_ff < mod_ff))
      else $error("reduced sum not below modulus");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("done without a finished reduction");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dynamic_array_range_aggregate.sv
// Ordered array with insert, erase, change, read, count and range query.
// Usage:
//   Requests enter on req_* (valid/stall) with a mode, first and last position
//   and a value; each item gives exactly one result on rsp_* (valid/stall)
//   carrying a 32-bit result and a status bit (1 for a bad position, a full
//   array, an empty range or a zero sum modulus; the array is then left unchanged).
//   combine_mode (csr index 0) and modulus (csr index 1) are written through
//   csr_we/csr_index/csr_wdata; the user must write them while no item is in flight (not enforced by the block).
// Sequencing:
//   One item is processed at a time; req_stall is high until its result has
//   been moved into the output register. Count, change, error and append items
//   go straight to the output stage; read first waits for the registered memory
//   data. Insert and erase walk the shifted entries through the element memory,
//   one entry per cycle. A range query walks the entries from first to last; a
//   sum range then adds the bit-serial modulo unit.
// Reset:
//   Synchronous reset empties the array (count 0), selects sum mode and loads
//   modulus 1000000007. Memory contents are not cleared.
// Backpressure:
//   A held rsp_stall keeps the result in the output register; the next item is
//   still accepted and processed, and waits for the output register to free up.
`default_nettype none

module dynamic_array_range_aggregate #(
   parameter int DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [dara_pkg::OP_W-1:0]         req_mode,
   input  wire logic [dara_pkg::POS_W-1:0]        req_first_pos,
   input  wire logic [dara_pkg::POS_W-1:0]        req_last_pos,
   input  wire logic signed [dara_pkg::VAL_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [dara_pkg::VAL_W-1:0]      rsp_result,
   output logic                                   rsp_status,
   input  wire logic                              csr_we,
   input  wire logic [dara_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dara_pkg::MOD_W-1:0]        csr_wdata
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int XW    = (CW > dara_pkg::POS_W) ? CW : dara_pkg::POS_W;
   localparam int SUM_W = dara_pkg::VAL_W + AW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDWAIT = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_LAST   = 3'd3;
   localparam logic [2:0] S_POST   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0]                 state_ff, state_in;
   dara_pkg::op_type           op_ff, op_in;
   logic [XW-1:0]              p_ff, p_in;
   logic [XW-1:0]              q_ff, q_in;
   logic [dara_pkg::VAL_W-1:0] v_ff, v_in;
   logic [CW-1:0]              cursor_ff, cursor_in;
   logic                       pend_ff, pend_in;
   logic [AW-1:0]              dst_ff, dst_in;
   logic [SUM_W-1:0]           acc_ff, acc_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [dara_pkg::VAL_W-1:0] res_ff, res_in;
   logic                       stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dara_pkg::VAL_W-1:0] rsp_result_ff, rsp_result_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic                       combine_ff, combine_in;
   logic [dara_pkg::MOD_W-1:0] modulus_ff, modulus_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [dara_pkg::VAL_W-1:0] wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [dara_pkg::VAL_W-1:0] rd_data;

   logic                       mr_start;
   logic                       mr_done;
   logic [dara_pkg::MOD_W-1:0] mr_result;

   logic [XW-1:0]              p_x;
   logic [XW-1:0]              q_x;
   logic [XW-1:0]              count_x;
   logic [XW-1:0]              cur_x;
   logic [CW-1:0]              last_idx;
   logic [SUM_W-1:0]           rd_sext;
   logic                       out_free;

   dara_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dara_modred #(
      .SUM_W (SUM_W)
   ) u_modred (
      .clock   (clock),
      .reset   (reset),
      .start   (mr_start),
      .sum     (acc_ff),
      .modulus (modulus_ff),
      .done    (mr_done),
      .result  (mr_result)
   );

   assign p_x      = XW'(req_first_pos);
   assign q_x      = XW'(req_last_pos);
   assign count_x  = XW'(count_ff);
   assign cur_x    = XW'(cursor_ff);
   assign last_idx = count_ff - CW'(1);
   assign rd_sext  = {{(SUM_W - dara_pkg::VAL_W){rd_data[dara_pkg::VAL_W-1]}}, rd_data};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      combine_in = combine_ff;
      modulus_in = modulus_ff;
      if (csr_we) begin
         if (csr_index == dara_pkg::CSR_COMBINE) begin
            combine_in = csr_wdata[0];
         end else if (csr_index == dara_pkg::CSR_MODULUS) begin
            modulus_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      v_in          = v_ff;
      cursor_in     = cursor_ff;
      pend_in       = 1'b0;
      dst_in        = dst_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = p_ff[AW-1:0];
      wr_data       = v_ff;
      rd_en         = 1'b0;
      rd_addr       = cursor_ff[AW-1:0];
      mr_start      = 1'b0;

      // Data read during the walk arrives in the following cycle: a shift writes it
      // to its new place, a range query folds it into the accumulator.
      if (pend_ff) begin
         if (op_ff == dara_pkg::OP_RANGE) begin
            if (combine_ff) begin
               acc_in = {acc_ff[SUM_W-1:dara_pkg::VAL_W],
                         acc_ff[dara_pkg::VAL_W-1:0] ^ rd_data};
            end else begin
               acc_in = acc_ff + rd_sext;
            end
         end else begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = rd_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_mode;
               p_in     = p_x;
               q_in     = q_x;
               v_in     = req_value;
               res_in   = '0;
               stat_in  = 1'b0;
               state_in = S_OUT;
               unique case (req_mode)
                  dara_pkg::OP_INSERT: begin
                     if ((count_ff == CW'(DEPTH)) || (p_x > count_x)) begin
                        stat_in = 1'b1;
                     end else if (p_x == count_x) begin
                        wr_en    = 1'b1;
                        wr_addr  = p_x[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                     end else begin
                        cursor_in = last_idx;
                        state_in  = S_WALK;
                     end
                  end
                  dara_pkg::OP_ERASE: begin
                     if (p_x >= count_x) begin
                        stat_in = 1'b1;
                     end else if (p_x == XW'(last_idx)) begin
                        count_in = last_idx;
                     end else begin
                        cursor_in = p_x[CW-1:0] + CW'(1);
                        state_in  = S_WALK;
                     end
                  end
                  dara_pkg::OP_CHANGE: begin
                     if (p_x >= count_x) begin
                        stat_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = p_x[AW-1:0];
                        wr_data = req_value;
                     end
                  end
                  dara_pkg::OP_READ: begin
                     if (p_x >= count_x) begin
                        stat_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = p_x[AW-1:0];
                        state_in = S_RDWAIT;
                     end
                  end
                  dara_pkg::OP_RANGE: begin
                     if ((p_x > q_x) || (q_x >= count_x) ||
                         (!combine_ff && (modulus_ff == '0))) begin
                        stat_in = 1'b1;
                     end else begin
                        cursor_in = p_x[CW-1:0];
                        acc_in    = '0;
                        state_in  = S_WALK;
                     end
                  end
                  default: begin
                     res_in = dara_pkg::VAL_W'(count_ff);
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            res_in   = rd_data;
            state_in = S_OUT;
         end
         S_WALK: begin
            rd_en   = 1'b1;
            rd_addr = cursor_ff[AW-1:0];
            pend_in = 1'b1;
            // Insert walks downward so no entry is overwritten before it moves;
            // erase and range queries walk upward.
            priority if (op_ff == dara_pkg::OP_INSERT) begin
               dst_in = cursor_ff[AW-1:0] + AW'(1);
               if (cur_x == p_ff) begin
                  state_in = S_LAST;
               end else begin
                  cursor_in = cursor_ff - CW'(1);
               end
            end else if (op_ff == dara_pkg::OP_ERASE) begin
               dst_in = cursor_ff[AW-1:0] - AW'(1);
               if (cursor_ff == last_idx) begin
                  state_in = S_LAST;
               end else begin
                  cursor_in = cursor_ff + CW'(1);
               end
            end else begin
               if (cur_x == q_ff) begin
                  state_in = S_LAST;
               end else begin
                  cursor_in = cursor_ff + CW'(1);
               end
            end
         end
         S_LAST: begin
            state_in = S_POST;
         end
         S_POST: begin
            priority if (op_ff == dara_pkg::OP_INSERT) begin
               wr_en    = 1'b1;
               wr_addr  = p_ff[AW-1:0];
               wr_data  = v_ff;
               count_in = count_ff + CW'(1);
               state_in = S_OUT;
            end else if (op_ff == dara_pkg::OP_ERASE) begin
               count_in = last_idx;
               state_in = S_OUT;
            end else if (combine_ff) begin
               res_in   = acc_ff[dara_pkg::VAL_W-1:0];
               state_in = S_OUT;
            end else begin
               mr_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (mr_done) begin
               res_in   = dara_pkg::VAL_W'(mr_result);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               rsp_status_in = stat_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         combine_ff   <= 1'b0;
         modulus_ff   <= dara_pkg::MODULUS_RST;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         combine_ff   <= combine_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      v_ff          <= v_in;
      cursor_ff     <= cursor_in;
      dst_ff        <= dst_in;
      acc_ff        <= acc_in;
      res_ff        <= res_in;
      stat_ff       <= stat_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond depth");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((state_ff == S_WALK) || (state_ff == S_LAST)))
      else $error("memory read data pending outside a walk");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_result_ff == '0))
      else $error("error result is not zero");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mr_done |-> (state_ff == S_DIV))
      else $error("modulo result arrived outside the wait state");
`endif

endmodule

`default_nettype wire
